>>> rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked every clock, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/btap_pkg.sv
// package: payload types, constants and state codes of the binomial pricer
`timescale 1ns / 1ps
package btap_pkg;
  localparam int unsigned MaxSteps = 1024;
  localparam int unsigned AddrW = $clog2(MaxSteps + 1);
  localparam int unsigned StepsW = 11;
  localparam logic [StepsW-1:0] StepsReset = 11'd256;
  localparam logic [30:0] OneQ30 = 31'h4000_0000;

  typedef struct packed {
    logic        is_call;
    logic [31:0] spot_price;
    logic [31:0] strike_price;
    logic [31:0] down_factor;
    logic [31:0] up_down_ratio;
    logic [30:0] up_probability;
    logic [30:0] discount_factor;
  } btap_in_t;

  typedef struct packed {
    logic [31:0] option_price;
    logic        saturated;
  } btap_out_t;

  typedef enum logic [11:0] {
    StIdle   = 12'b0000_0000_0001,
    StLvlMul = 12'b0000_0000_0010,
    StLvlWr  = 12'b0000_0000_0100,
    StLfRd   = 12'b0000_0000_1000,
    StLfWait = 12'b0000_0001_0000,
    StLfWr   = 12'b0000_0010_0000,
    StBkRd   = 12'b0000_0100_0000,
    StBkRd2  = 12'b0000_1000_0000,
    StBkMulA = 12'b0001_0000_0000,
    StBkMulB = 12'b0010_0000_0000,
    StBkMulC = 12'b0100_0000_0000,
    StBkWr   = 12'b1000_0000_0000
  } btap_state_e;

  function automatic logic [31:0] btap_exercise(logic call, logic [31:0] s, logic [31:0] k);
    logic [31:0] r;
    r = '0;
    if (call) begin
      if (s > k) r = s - k;
    end else begin
      if (k > s) r = k - s;
    end
    return r;
  endfunction
endpackage

>>> rtl/btap_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module btap_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

>>> rtl/binomial_tree_american_price.sv
// top level: american option pricer on a recombining binomial tree
//
//  channel  | direction | handshake           | payload
//  in       | input     | in_valid_i/stall_o  | btap_in_t
//  out      | output    | out_valid_o/stall_i | btap_out_t
//  cfg      | input     | cfg_we_i            | tree_steps
//
// the backward pass, one node at a time through the shared multiplier,
// takes up most of a request. no reset pass: the rams hold only what the
// request writes. a finished result sits in the output register until
// taken; a new request is accepted once the pricer is idle and the
// output register is free or being taken.
`timescale 1ns / 1ps
module binomial_tree_american_price import btap_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  btap_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output btap_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [StepsW-1:0] cfg_wdata_i
);
  btap_state_e st_q, st_d;
  logic [StepsW-1:0] steps_q;
  btap_in_t req_q;
  logic [AddrW-1:0] n_q, lvl_q, idx_q;
  logic [31:0] spot_q, vdn_q, vup_q, x_q;
  logic [63:0] acc_q;
  logic clip_q, ovalid_q;
  btap_out_t out_q;

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = {32'd0, ma} * {32'd0, mb};
  logic [63:0] rnd;
  assign rnd = (acc_q + 64'h2000_0000) >> 30;
  logic [31:0] sat;
  assign sat = (rnd[63:32] != 0) ? 32'hFFFF_FFFF : rnd[31:0];
  logic [63:0] scale_r;
  assign scale_r = (mp + 64'h2000_0000) >> 30;
  logic [31:0] scale_s;
  logic scale_c;
  assign scale_c = scale_r[63:32] != 0;
  assign scale_s = scale_c ? 32'hFFFF_FFFF : scale_r[31:0];

  logic lw_we, nw_we;
  logic [AddrW-1:0] l_addr, n_addr;
  logic [31:0] l_wd, n_wd, l_rd, n_rd;
  btap_ram #(.Width(32), .Depth(MaxSteps + 1)) u_lvl (
    .clk_i, .we_i(lw_we), .addr_i(l_addr), .wdata_i(l_wd), .rdata_o(l_rd));
  btap_ram #(.Width(32), .Depth(MaxSteps + 1)) u_node (
    .clk_i, .we_i(nw_we), .addr_i(n_addr), .wdata_i(n_wd), .rdata_o(n_rd));

  logic [30:0] p_c, d_c;
  assign p_c = (req_q.up_probability > OneQ30) ? OneQ30 : req_q.up_probability;
  assign d_c = (req_q.discount_factor > OneQ30) ? OneQ30 : req_q.discount_factor;
  logic accept;
  assign in_stall_o = (st_q != StIdle) || (ovalid_q && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;
  logic [31:0] cont;
  assign cont = sat;

  always_comb begin
    st_d = st_q;
    ma = spot_q; mb = req_q.down_factor;
    lw_we = 1'b0; nw_we = 1'b0;
    l_addr = lvl_q; n_addr = idx_q;
    l_wd = spot_q; n_wd = '0;
    case (st_q)
      StIdle:   if (accept) st_d = StLvlMul;
      StLvlMul: st_d = StLvlWr;
      StLvlWr: begin
        lw_we = 1'b1;
        st_d = (lvl_q == n_q) ? StLfRd : StLvlMul;
      end
      StLfRd:   st_d = StLfWait;
      StLfWait: st_d = StLfWr;
      StLfWr: begin
        ma = spot_q; mb = req_q.up_down_ratio;
        nw_we = 1'b1;
        n_wd = btap_exercise(req_q.is_call, spot_q, req_q.strike_price);
        st_d = (idx_q == n_q) ? StBkRd : StLfWr;
      end
      StBkRd:   st_d = StBkRd2;
      StBkRd2: begin
        n_addr = idx_q + 1'b1;
        st_d = StBkMulA;
      end
      StBkMulA: begin
        n_addr = idx_q + 1'b1;
        ma = vdn_q; mb = {1'b0, OneQ30 - p_c};
        st_d = StBkMulB;
      end
      StBkMulB: begin
        ma = vup_q; mb = {1'b0, p_c};
        st_d = StBkMulC;
      end
      StBkMulC: begin
        ma = cont; mb = {1'b0, d_c};
        st_d = StBkWr;
      end
      StBkWr: begin
        ma = spot_q; mb = req_q.up_down_ratio;
        nw_we = 1'b1;
        n_wd = (sat > x_q) ? sat : x_q;
        if (idx_q == lvl_q) st_d = (lvl_q == 0) ? StIdle : StBkRd;
        else st_d = StBkRd2;
        if (idx_q != lvl_q) n_addr = idx_q;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      steps_q <= StepsReset;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) steps_q <= cfg_wdata_i;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (st_q == StBkWr && idx_q == lvl_q && lvl_q == 0) ovalid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (accept) begin
        req_q <= in_data_i;
        spot_q <= in_data_i.spot_price;
        lvl_q <= '0;
        clip_q <= 1'b0;
        if (steps_q == 0) n_q <= AddrW'(1);
        else if (steps_q > StepsW'(MaxSteps)) n_q <= AddrW'(MaxSteps);
        else n_q <= AddrW'(steps_q);
      end
      StLvlMul: ;
      StLvlWr: begin
        if (lvl_q != n_q) begin
          spot_q <= scale_s;
          clip_q <= clip_q | scale_c;
          lvl_q <= lvl_q + 1'b1;
        end
        idx_q <= '0;
      end
      StLfRd, StLfWait: ;
      StLfWr: begin
        if (idx_q != n_q) begin
          spot_q <= scale_s;
          clip_q <= clip_q | scale_c;
          idx_q <= idx_q + 1'b1;
        end else begin
          lvl_q <= n_q - 1'b1;
          idx_q <= '0;
        end
      end
      StBkRd: ;
      StBkRd2: begin
        // later nodes of a level reuse the upper child of the node before
        vdn_q <= (idx_q == 0) ? n_rd : vup_q;
        if (idx_q == 0) spot_q <= l_rd;
      end
      StBkMulA: begin
        vup_q <= n_rd;
        acc_q <= mp;
      end
      StBkMulB: begin
        acc_q <= acc_q + mp;
        x_q <= btap_exercise(req_q.is_call, spot_q, req_q.strike_price);
      end
      StBkMulC: acc_q <= mp;
      StBkWr: begin
        if (idx_q != lvl_q) begin
          spot_q <= scale_s;
          clip_q <= clip_q | scale_c;
          idx_q <= idx_q + 1'b1;
        end else begin
          idx_q <= '0;
          if (lvl_q != 0) lvl_q <= lvl_q - 1'b1;
          else begin
            out_q.option_price <= (sat > x_q) ? sat : x_q;
            out_q.saturated <= clip_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o = out_q;
endmodule

>>> rtl/btap_checker.sv
// port-level checker for the pricer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module btap_checker import btap_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input btap_out_t out_data_o
);
  `ASSERT_NEXT(busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_NEXT(out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `ASSERT_NEXT(no_out_right_after, clk_i, rst_ni, in_valid_i && !in_stall_o, !out_valid_o || $past(out_valid_o))
endmodule

bind binomial_tree_american_price btap_checker u_btap_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o);

>>> tb/tb_top.sv
// testbench for the binomial tree american option pricer: self-checking, random stalls
`timescale 1ns / 1ps
module tb_top;
  import btap_pkg::*;

  localparam longint unsigned ONE_Q30  = 64'h4000_0000;
  localparam longint unsigned HALF_Q30 = 64'h2000_0000;
  localparam int unsigned     QUIET_LIMIT = 12_000_000;
  localparam int unsigned     DRAIN_CYCLES = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  btap_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b1;
  btap_out_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic [StepsW-1:0] cfg_wdata_i = '0;

  logic [StepsW-1:0] steps_q = StepsReset;
  btap_out_t price_q[$];
  int unsigned err_cnt = 0;
  int unsigned hold_off = 0;
  bit steady = 1'b0;
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  binomial_tree_american_price uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // spot times q2.30 factor, round half up, clip at full scale
  function automatic logic [31:0] scale_q30(logic [31:0] s, logic [31:0] f, ref bit clip);
    logic [63:0] prod;
    prod = ({32'b0, s} * {32'b0, f} + HALF_Q30) >> 30;
    if (prod > 64'hFFFF_FFFF) begin
      clip = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return prod[31:0];
  endfunction

  function automatic logic [31:0] payoff(logic call, logic [31:0] s, logic [31:0] k);
    if (call) return (s > k) ? s - k : 32'd0;
    return (k > s) ? k - s : 32'd0;
  endfunction

  function automatic btap_out_t price_american(btap_in_t req, logic [StepsW-1:0] steps);
    logic [31:0] vals[MaxSteps+1];
    logic [31:0] lvl_spot[MaxSteps+1];
    logic [31:0] s, c, x;
    longint unsigned p, disc, e, d;
    bit clip;
    int n;
    btap_out_t res;
    clip = 1'b0;
    n = steps;
    if (n == 0) n = 1;
    if (n > MaxSteps) n = MaxSteps;
    p = req.up_probability;
    disc = req.discount_factor;
    if (p > ONE_Q30) p = ONE_Q30;
    if (disc > ONE_Q30) disc = ONE_Q30;
    lvl_spot[0] = req.spot_price;
    for (int l = 1; l <= n; l++) lvl_spot[l] = scale_q30(lvl_spot[l-1], req.down_factor, clip);
    s = lvl_spot[n];
    for (int i = 0; i <= n; i++) begin
      vals[i] = payoff(req.is_call, s, req.strike_price);
      if (i < n) s = scale_q30(s, req.up_down_ratio, clip);
    end
    for (int l = n - 1; l >= 0; l--) begin
      s = lvl_spot[l];
      for (int i = 0; i <= l; i++) begin
        e = (p * vals[i+1] + (ONE_Q30 - p) * vals[i] + HALF_Q30) >> 30;
        d = (e * disc + HALF_Q30) >> 30;
        c = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
        x = payoff(req.is_call, s, req.strike_price);
        vals[i] = (c > x) ? c : x;
        if (i < l) s = scale_q30(s, req.up_down_ratio, clip);
      end
    end
    res.option_price = vals[0];
    res.saturated = clip;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    err_cnt++;
  endtask

  // sender: random gaps, beat taken at a rising edge with stall low
  task automatic send_request(btap_in_t req);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = req;
    do @(posedge clk_i); while (in_stall_o);
    price_q.push_back(price_american(req, steps_q));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_steps(logic [StepsW-1:0] n);
    wait (price_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = n;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    steps_q = n;
  endtask

  // well-formed market data most of the time, raw noise otherwise
  function automatic btap_in_t rand_request();
    btap_in_t r;
    r.is_call = 1'($urandom_range(1));
    r.spot_price = $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
    r.strike_price = r.spot_price + $urandom_range(32'h0010_0000) - 32'h0008_0000;
    r.down_factor = $urandom_range(32'h4000_0000, 32'h3800_0000);
    r.up_down_ratio = $urandom_range(32'h5000_0000, 32'h4000_0000);
    r.up_probability = 31'($urandom_range(32'h4000_0000));
    r.discount_factor = 31'($urandom_range(32'h4000_0000, 32'h3F00_0000));
    if ($urandom_range(99) < 25) begin
      r.spot_price = $urandom;
      r.strike_price = $urandom;
      r.down_factor = $urandom;
      r.up_down_ratio = $urandom;
      r.up_probability = 31'($urandom);
      r.discount_factor = 31'($urandom);
    end
    return r;
  endfunction

  function automatic btap_in_t make_req(logic call, logic [31:0] s, logic [31:0] k,
                                        logic [31:0] dn, logic [31:0] ud,
                                        logic [30:0] p, logic [30:0] disc);
    btap_in_t r;
    r = '{is_call: call, spot_price: s, strike_price: k, down_factor: dn,
          up_down_ratio: ud, up_probability: p, discount_factor: disc};
    return r;
  endfunction

  task automatic test_reset_steps();
    send_request(make_req(1'b0, 32'h0064_0000, 32'h0064_0000, 32'h3F00_0000,
                          32'h4200_0000, 31'h2000_0000, 31'h3FF0_0000));
  endtask

  task automatic test_directed();
    write_steps(11'd3);
    send_request(make_req(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 31'h0));
    send_request(make_req(1'b0, 32'h0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h4000_0000,
                          OneQ30, OneQ30));
    send_request(make_req(1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          OneQ30, OneQ30));
    send_request(make_req(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_request(make_req(1'b1, 32'h0064_0000, 32'h0050_0000, 32'h3C00_0000,
                          32'h4800_0000, 31'h7FFF_FFFF, 31'h3F80_0000));
    // deep in the money put: early exercise wins at every node
    send_request(make_req(1'b0, 32'h000A_0000, 32'h0064_0000, 32'h3C00_0000,
                          32'h4800_0000, 31'h2000_0000, 31'h3000_0000));
    send_request(make_req(1'b1, 32'h0064_0000, 32'h0064_0000, 32'h3C00_0000,
                          32'h4800_0000, 31'h0, 31'h3FFF_0000));
    send_request(make_req(1'b0, 32'h0064_0000, 32'h0064_0000, 32'h0, 32'h0,
                          31'h2000_0000, 31'h0));
    send_request(make_req(1'b1, 32'h0001_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                          31'h2AAA_AAAA, 31'h3FFF_FFFF));
    send_request(make_req(1'b0, 32'h0064_0000, 32'h0, 32'h3C00_0000, 32'h4800_0000,
                          31'h2000_0000, OneQ30));
  endtask

  task automatic test_steps_extremes();
    write_steps(11'd0);
    send_request(rand_request());
    send_request(rand_request());
    write_steps(11'd1);
    send_request(rand_request());
    write_steps(11'd1024);
    write_steps(11'h7FF);
    send_request(make_req(1'b0, 32'h0064_0000, 32'h0064_0000, 32'h3FF0_0000,
                          32'h4020_0000, 31'h2000_0000, 31'h3FFF_F000));
  endtask

  // receiver holds off while short requests keep coming, so the input stalls
  task automatic test_backpressure();
    write_steps(11'd1);
    @(negedge clk_i);
    hold_off = 300;
    steady = 1'b1;
    repeat (8) send_request(rand_request());
    steady = 1'b0;
  endtask

  task automatic test_random();
    for (int k = 0; k < 80; k++) begin
      if (k % 10 == 0)
        write_steps(($urandom_range(9) == 0) ? 11'd40 : StepsW'($urandom_range(12, 1)));
      steady = (k >= 40 && k < 55);
      send_request(rand_request());
    end
    steady = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 38);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (price_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data_o.option_price, 32'h0);
      end else begin
        if (out_data_o.option_price !== price_q[0].option_price)
          report_mismatch("option_price", out_data_o.option_price, price_q[0].option_price);
        if (out_data_o.saturated !== price_q[0].saturated)
          report_mismatch("saturated", 32'(out_data_o.saturated),
                          32'(price_q[0].saturated));
        void'(price_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_steps();
    test_directed();
    test_steps_extremes();
    test_backpressure();
    test_random();
    wait (price_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
